/* rtl/core/stg_pkg.sv */
// ---------------------------------------------------------------------------
// stg_pkg
// Shared types, widths, register codes and the sine table function of the
// tone generator.
// ---------------------------------------------------------------------------
package stg_pkg;

	localparam int SINE_DEPTH_DEF = 1024;
	localparam int COUNT_W_DEF    = 16;

	localparam int PHASE_W    = 32;
	localparam int PHASE_HI_W = 16;
	localparam int NOTE_W     = 16;
	localparam int AMP_W      = 16;
	localparam int ATK_W      = 16;
	localparam int IDX_W      = 16;
	localparam int TOTAL_W    = 17;
	localparam int MAG_W      = 15;
	localparam int SAMPLE_W   = 16;
	localparam int ENV_W      = 17;
	localparam int FRAC_W     = 16;
	localparam int DIV_CNT_W  = $clog2(FRAC_W + 1);
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [AMP_W-1:0] AMP_RESET = 16'd36045;
	localparam logic [ATK_W-1:0] ATK_RESET = 16'd80;

	// floor(n/3) == (n * 43691) >> 17 for n < 2^17
	localparam logic [15:0] DIV3_RECIP = 16'd43691;
	localparam int          DIV3_SHIFT = 17;

	localparam logic [63:0] PI_Q30     = 64'd3373259426;
	localparam logic [63:0] FULL_SCALE = 64'd32767;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_STEP   = 4'd0,
		REG_NOTE_SAMPLES = 4'd1,
		REG_AMPLITUDE    = 4'd2,
		REG_ATTACK       = 4'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ATTACK,
		BK_ATK_WAIT,
		BK_DECAY,
		BK_DEC_WAIT,
		BK_SCALE,
		BK_MUL,
		BK_OUT
	} bk_state_t;

	typedef struct packed {
		logic start_req;
	} tick_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
		logic                       active;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_word_t;

	typedef struct packed {
		logic [AMP_W-1:0] amplitude_q16;
		logic [ATK_W-1:0] attack_samples;
	} gain_cfg_t;

	typedef struct packed {
		logic                  active;
		logic                  last;
		logic [IDX_W-1:0]      idx;
		logic [TOTAL_W-1:0]    total;
		logic [TOTAL_W-1:0]    from_end;
		logic [PHASE_HI_W-1:0] phase_hi;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [FRAC_W-1:0] num;
		logic [FRAC_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [FRAC_W-1:0] quo;
	} div_rsp_t;

	// 32767*sin(m/2^qaw * pi/2), Q30 Taylor series, elaboration only
	function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned m,
		input int unsigned qaw);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		x    = (64'(m) * PI_Q30) >> (qaw + 1);
		x2   = (x * x) >> 30;
		sum  = x;
		term = x;
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
		term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
		term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
		term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
		term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
		term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
		term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
		v = (sum * FULL_SCALE + (64'd1 << 29)) >> 30;
		return (v > FULL_SCALE) ? FULL_SCALE[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

endpackage

/* rtl/core/stg_chan_if.sv */
// ---------------------------------------------------------------------------
// stg_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ---------------------------------------------------------------------------
interface stg_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/sine_tone_envelope_generator.sv */
// A word outside a note goes straight to the output register; a played sample
// passes attack and decay (a gain division each when needed), scale and multiply.
// The back end finishes one word before taking the next; the front end takes a
// tick per cycle into a 2-word queue while it has room and no cfg write is valid.
// Reset (arst_n low, asynchronous) clears note state and queue and loads
// register defaults; no clearing pass follows.
// ---------------------------------------------------------------------------
// sine_tone_envelope_generator
// DDS sine tone with linear attack and decay envelope, one sample per tick.
// ---------------------------------------------------------------------------
module sine_tone_envelope_generator #(
	parameter int SINE_TABLE_DEPTH = stg_pkg::SINE_DEPTH_DEF,
	parameter int COUNT_WIDTH      = stg_pkg::COUNT_W_DEF
) (
	input logic  clk,
	input logic  arst_n,
	stg_chan_if.sink   tick,
	stg_chan_if.sink   cfg,
	stg_chan_if.source result
);
	import stg_pkg::*;

	stg_chan_if #(.T(entry_t)) q_push ();
	stg_chan_if #(.T(entry_t)) q_pop ();

	gain_cfg_t gain;
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	stg_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.cfg    (cfg),
		.push   (q_push),
		.gain   (gain)
	);

	stg_fifo #(
		.T     (entry_t),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (q_pop)
	);

	stg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	stg_back #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop     (q_pop),
		.gain    (gain),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.result  (result)
	);
endmodule

/* rtl/core/stg_div.sv */
// ---------------------------------------------------------------------------
// stg_div
// Bit-serial restoring divider: quo = (num << 16) / den for num < den,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
module stg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  stg_pkg::div_req_t req,
	output stg_pkg::div_rsp_t rsp
);
	import stg_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FRAC_W-1:0]    rem_q;
	logic [FRAC_W-1:0]    den_q;
	logic [FRAC_W-1:0]    quo_q;
	logic [FRAC_W:0]      shifted;
	logic                 ge;
	logic [FRAC_W-1:0]    rem_next;

	assign shifted  = {rem_q, 1'b0};
	assign ge       = shifted >= {1'b0, den_q};
	assign rem_next = ge ? FRAC_W'(shifted - {1'b0, den_q}) : shifted[FRAC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(FRAC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[FRAC_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

/* rtl/core/stg_fifo.sv */
// ---------------------------------------------------------------------------
// stg_fifo
// Small register queue between the tick front end and the sample back end.
// ---------------------------------------------------------------------------
module stg_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = stg_pkg::QUEUE_DEPTH
) (
	input logic  clk,
	input logic  arst_n,
	stg_chan_if.sink   push,
	stg_chan_if.source pop
);
	import stg_pkg::*;

	localparam int PW = $clog2(DEPTH) + 1;

	T              mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic          empty;
	logic          full;
	logic          do_push;
	logic          do_pop;

	assign empty   = wr_q == rd_q;
	assign full    = (wr_q[PW-1] != rd_q[PW-1]) && (wr_q[PW-2:0] == rd_q[PW-2:0]);
	assign do_push = push.valid && !full;
	assign do_pop  = pop.ready && !empty;

	assign push.ready = !full;
	assign pop.valid  = !empty;
	assign pop.data   = mem_q[rd_q[PW-2:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + PW'(1);
			if (do_pop)  rd_q <= rd_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q[PW-2:0]] <= push.data;
	end
endmodule

/* rtl/core/stg_front.sv */
// ---------------------------------------------------------------------------
// stg_front
// Register file and note sequencer: takes a tick per cycle when the queue has room
// and cfg is idle, steps index and phase, queues a classified word for the back end.
// ---------------------------------------------------------------------------
module stg_front #(
	parameter int COUNT_WIDTH = stg_pkg::COUNT_W_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	stg_chan_if.sink   tick,
	stg_chan_if.sink   cfg,
	stg_chan_if.source push,
	output stg_pkg::gain_cfg_t gain
);
	import stg_pkg::*;

	localparam logic [TOTAL_W-1:0] CAP = (COUNT_WIDTH >= NOTE_W) ?
		(TOTAL_W'(1) << NOTE_W) : (TOTAL_W'(1) << COUNT_WIDTH);

	logic [PHASE_W-1:0]     phase_step_q;
	logic [NOTE_W-1:0]      note_q;
	logic [AMP_W-1:0]       amp_q;
	logic [ATK_W-1:0]       atk_q;
	logic [COUNT_WIDTH-1:0] idx_q;
	logic [PHASE_W-1:0]     phase_q;
	logic                   playing_q;

	logic [TOTAL_W-1:0]     total;
	logic [COUNT_WIDTH-1:0] cur_idx;
	logic [PHASE_W-1:0]     cur_phase;
	logic                   cur_play;
	logic [31:0]            idx_ext;
	logic [31:0]            idx_inc;
	logic [31:0]            total_ext;
	logic                   live;
	logic                   ended;
	logic                   accept;
	entry_t                 entry;

	assign total     = ({1'b0, note_q} > CAP) ? CAP : {1'b0, note_q};
	assign cur_idx   = tick.data.start_req ? '0 : idx_q;
	assign cur_phase = tick.data.start_req ? '0 : phase_q;
	assign cur_play  = tick.data.start_req || playing_q;
	assign idx_ext   = 32'(cur_idx);
	assign idx_inc   = idx_ext + 32'd1;
	assign total_ext = 32'(total);
	assign live      = cur_play && (idx_ext < total_ext);
	assign ended     = idx_inc >= total_ext;

	assign accept     = tick.valid && tick.ready;
	assign tick.ready = push.ready && !cfg.valid;
	assign push.valid = tick.valid && !cfg.valid;
	assign cfg.ready  = 1'b1;

	always_comb begin
		entry.active   = live;
		entry.last     = live && ended;
		entry.idx      = IDX_W'(cur_idx);
		entry.total    = total;
		entry.from_end = total - TOTAL_W'(cur_idx);
		entry.phase_hi = cur_phase[PHASE_W-1 -: PHASE_HI_W];
	end

	assign push.data = entry;
	assign gain.amplitude_q16  = amp_q;
	assign gain.attack_samples = atk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			note_q       <= '0;
			amp_q        <= AMP_RESET;
			atk_q        <= ATK_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_PHASE_STEP:   phase_step_q <= cfg.data.wdata;
				REG_NOTE_SAMPLES: note_q       <= cfg.data.wdata[NOTE_W-1:0];
				REG_AMPLITUDE:    amp_q        <= cfg.data.wdata[AMP_W-1:0];
				REG_ATTACK:       atk_q        <= cfg.data.wdata[ATK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			phase_q   <= '0;
			playing_q <= 1'b0;
		end else if (accept) begin
			if (!live) begin
				idx_q     <= cur_idx;
				phase_q   <= cur_phase;
				playing_q <= 1'b0;
			end else begin
				phase_q <= cur_phase + phase_step_q;
				if (ended) begin
					idx_q     <= '0;
					playing_q <= 1'b0;
				end else begin
					idx_q     <= COUNT_WIDTH'(idx_inc);
					playing_q <= 1'b1;
				end
			end
		end
	end
endmodule

/* rtl/core/stg_back.sv */
// ---------------------------------------------------------------------------
// stg_back
// Sample sequencer: sine lookup, attack and decay gains through the shared
// divider, amplitude and envelope scaling, output register.
// ---------------------------------------------------------------------------
module stg_back #(
	parameter int SINE_TABLE_DEPTH = stg_pkg::SINE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	stg_chan_if.sink   pop,
	input  stg_pkg::gain_cfg_t gain,
	output stg_pkg::div_req_t  div_req,
	input  stg_pkg::div_rsp_t  div_rsp,
	stg_chan_if.source result
);
	import stg_pkg::*;

	localparam int TAB_W = $clog2(SINE_TABLE_DEPTH);
	localparam int QAW   = TAB_W - 2;
	localparam int AW    = QAW + 1;
	localparam int QN    = (1 << QAW) + 1;
	localparam int P1_W  = MAG_W + AMP_W;
	localparam int P2_W  = P1_W + ENV_W;
	localparam int DP_W  = TOTAL_W + 16;
	localparam int EP_W  = ENV_W + FRAC_W;
	localparam logic [AW-1:0]    QUARTER = AW'(1) << QAW;
	localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1) << FRAC_W;

	logic [MAG_W-1:0] quarter_rom [QN];

	for (genvar gi = 0; gi < QN; gi++) begin : g_rom
		assign quarter_rom[gi] = quarter_sine(gi, QAW);
	end

	bk_state_t state_q;
	bk_state_t state_d;

	entry_t            ent_q;
	logic [MAG_W-1:0]  rom_q;
	logic              neg_q;
	logic [FRAC_W-1:0] decay_q;
	logic [ENV_W-1:0]  env_q;
	logic [P1_W-1:0]   p1_q;
	logic [SAMPLE_W-1:0] mag_q;
	result_t           res_q;
	logic              res_valid_q;

	logic [TAB_W-1:0]  k;
	logic [QAW-1:0]    m;
	logic [AW-1:0]     rom_addr;
	logic [DP_W-1:0]   d_prod;
	logic [EP_W-1:0]   env_prod;
	logic [P1_W-1:0]   p1;
	logic [P2_W-1:0]   p2;
	logic              atk_needed;
	logic              dec_needed;
	logic              load_out;

	assign k        = ent_q.phase_hi[PHASE_HI_W-1 -: TAB_W];
	assign m        = k[QAW-1:0];
	assign rom_addr = k[TAB_W-2] ? (QUARTER - {1'b0, m}) : {1'b0, m};
	assign d_prod   = DP_W'(ent_q.total) * DP_W'(DIV3_RECIP);
	assign env_prod = EP_W'(env_q) * EP_W'(div_rsp.quo);
	assign p1       = P1_W'(rom_q) * P1_W'(gain.amplitude_q16);
	assign p2       = P2_W'(p1_q) * P2_W'(env_q);

	assign atk_needed = ent_q.idx < gain.attack_samples;
	assign dec_needed = ent_q.from_end < TOTAL_W'(decay_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop.valid) state_d = pop.data.active ? BK_ATTACK : BK_OUT;
			end
			BK_ATTACK:   state_d = atk_needed ? BK_ATK_WAIT : BK_DECAY;
			BK_ATK_WAIT: if (div_rsp.done) state_d = BK_DECAY;
			BK_DECAY:    state_d = dec_needed ? BK_DEC_WAIT : BK_SCALE;
			BK_DEC_WAIT: if (div_rsp.done) state_d = BK_SCALE;
			BK_SCALE:    state_d = BK_MUL;
			BK_MUL:      state_d = BK_OUT;
			BK_OUT:      if (load_out) state_d = BK_IDLE;
			default:     state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop.ready     = 1'b0;
		load_out      = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = ent_q.idx;
		div_req.den   = gain.attack_samples;
		unique case (state_q)
			BK_IDLE:   pop.ready = 1'b1;
			BK_ATTACK: div_req.start = atk_needed;
			BK_DECAY: begin
				div_req.start = dec_needed;
				div_req.num   = ent_q.from_end[FRAC_W-1:0];
				div_req.den   = decay_q;
			end
			BK_OUT:    load_out = !res_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)          res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (pop.valid) begin
					ent_q <= pop.data;
					mag_q <= '0;
				end
			end
			BK_ATTACK: begin
				rom_q   <= quarter_rom[rom_addr];
				neg_q   <= k[TAB_W-1];
				decay_q <= d_prod[DIV3_SHIFT +: FRAC_W];
				env_q   <= ENV_ONE;
			end
			BK_ATK_WAIT: if (div_rsp.done) env_q <= {1'b0, div_rsp.quo};
			BK_DEC_WAIT: if (div_rsp.done) env_q <= env_prod[EP_W-1 -: ENV_W];
			BK_SCALE:    p1_q  <= p1;
			BK_MUL:      mag_q <= p2[P2_W-1 -: SAMPLE_W];
			default: ;
		endcase
		if (load_out) begin
			res_q.sample <= $signed(neg_q ? (SAMPLE_W'(0) - mag_q) : mag_q);
			res_q.last   <= ent_q.last;
			res_q.active <= ent_q.active;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;
endmodule

/* rtl/core/stg_checker.sv */
// ---------------------------------------------------------------------------
// stg_checker
// Port-level checks of the tone generator, bound to the top level.
// ---------------------------------------------------------------------------
module stg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        tick_ready,
	input logic        cfg_valid,
	input logic        result_valid,
	input logic        result_ready,
	input logic [15:0] result_sample,
	input logic        result_last,
	input logic        result_active
);
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped while stalled");

	a_last_active: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_last |-> result_active)
		else $error("last flagged on an inactive word");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_active |-> result_sample == 16'h0000)
		else $error("nonzero sample outside a note");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_sample != 16'h8000)
		else $error("sample magnitude beyond full scale");

	a_cfg_blocks_tick: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> !tick_ready)
		else $error("tick taken during a register write");
endmodule

bind sine_tone_envelope_generator stg_checker u_stg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.tick_ready    (tick.ready),
	.cfg_valid     (cfg.valid),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_sample (result.data.sample),
	.result_last   (result.data.last),
	.result_active (result.data.active)
);
